>>> hdl/assert_macros.svh
// Concurrent assertion helpers; clk and rst_n must be visible where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define UPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("upd assertion failed");

// Next-cycle implication, off while in reset.
`define UPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("upd assertion failed");

// Next-cycle implication, checked through reset as well.
`define UPD_ASSERT_NEXT_NR(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("upd assertion failed");

`endif

>>> hdl/upd_pkg.sv
`timescale 1ns / 1ps

package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PCT,
    PH_DIG
  } phase_t;

  // Up to three decoded bytes released by one input byte; last applies to
  // the final byte of the group.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            last;
  } grp_t;

  // Bit 4 set: not a hex digit. Bits 3:0: digit value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic is_num;
    logic is_upper;
    logic is_lower;
    logic [3:0] val;
    is_num   = (c >= 8'h30) && (c <= 8'h39);
    is_upper = (c >= 8'h41) && (c <= 8'h46);
    is_lower = (c >= 8'h61) && (c <= 8'h66);
    val      = c[6] ? (c[3:0] + 4'd9) : c[3:0];
    return {!(is_num || is_upper || is_lower), val};
  endfunction

endpackage

>>> hdl/upd_in_if.sv
`timescale 1ns / 1ps

interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

>>> hdl/upd_out_if.sv
`timescale 1ns / 1ps

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

>>> hdl/upd_front.sv
`timescale 1ns / 1ps

module upd_front (
  input  logic          clk,
  input  logic          rst_n,
  upd_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output upd_pkg::grp_t grp
);
  import upd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;

  logic       acc;
  logic [4:0] hv;
  logic [4:0] held_hv;
  logic       is_hex;
  logic [1:0] pre_cnt;
  logic       do_plain;
  logic       dec_emit;
  logic       emit;
  logic [7:0] emit_byte;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign hv          = hex_value(in_ch.in_byte);
  assign held_hv     = hex_value(held_r);
  assign is_hex      = !hv[4];

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    pre_cnt   = 2'd0;
    do_plain  = 1'b0;
    dec_emit  = 1'b0;
    emit      = 1'b0;
    emit_byte = in_ch.in_byte;

    unique case (phase_r)
      PH_PCT: begin
        if (is_hex && !in_ch.in_last) begin
          held_nxt  = in_ch.in_byte;
          phase_nxt = PH_DIG;
        end else begin
          // flush the literal '%', then treat the byte as plain text
          pre_cnt  = 2'd1;
          do_plain = 1'b1;
        end
      end
      PH_DIG: begin
        if (is_hex) begin
          dec_emit  = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          pre_cnt  = 2'd2;
          do_plain = 1'b1;
        end
      end
      default: do_plain = 1'b1;
    endcase

    if (dec_emit) begin
      emit      = 1'b1;
      emit_byte = {held_hv[3:0], hv[3:0]};
    end else if (do_plain) begin
      if (in_ch.in_byte == CH_PERCENT && !in_ch.in_last) begin
        phase_nxt = PH_PCT;
      end else begin
        emit      = 1'b1;
        emit_byte = (in_ch.in_byte == CH_PLUS) ? CH_SPACE : in_ch.in_byte;
        phase_nxt = PH_IDLE;
      end
    end

    grp.cnt      = pre_cnt + {1'b0, emit};
    grp.last     = in_ch.in_last;
    grp.bytes[0] = (pre_cnt == 2'd0) ? emit_byte : CH_PERCENT;
    grp.bytes[1] = (pre_cnt == 2'd1) ? emit_byte : held_r;
    grp.bytes[2] = emit_byte;
  end

  assign push = acc && (grp.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'd0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

>>> hdl/upd_queue.sv
`timescale 1ns / 1ps

module upd_queue #(
  parameter int Depth = upd_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  upd_pkg::grp_t wr,
  output logic          full,
  input  logic          pop,
  output upd_pkg::grp_t rd,
  output logic          empty
);
  import upd_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

  grp_t          mem_r [Depth];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(Depth));
  assign empty = (cnt_r == '0);
  assign rd    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == LastIdx) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == LastIdx) ? '0 : rp_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr;
    end
  end

endmodule

>>> hdl/upd_back.sv
`timescale 1ns / 1ps

module upd_back (
  input  logic          clk,
  input  logic          rst_n,
  upd_out_if.source     out_ch,
  input  upd_pkg::grp_t rd,
  input  logic          empty,
  output logic          pop
);
  import upd_pkg::*;

  grp_t       cur_r;
  logic       cur_v_r, cur_v_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       take;
  logic       final_beat;

  assign take       = out_ch.valid && out_ch.ready;
  assign final_beat = (idx_r == (cur_r.cnt - 2'd1));

  // load the next group when idle or when the last beat of this one leaves
  assign pop = !empty && (!cur_v_r || (take && final_beat));

  assign out_ch.valid    = cur_v_r;
  assign out_ch.out_byte = cur_r.bytes[idx_r];
  assign out_ch.out_last = cur_r.last && final_beat;

  always_comb begin
    cur_v_nxt = cur_v_r;
    idx_nxt   = idx_r;
    if (pop) begin
      cur_v_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end else if (take) begin
      if (final_beat) begin
        cur_v_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      cur_v_r <= cur_v_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= rd;
    end
  end

endmodule

>>> hdl/url_percent_decoder.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    in_byte[7:0], in_last
// out_ch    out  valid/ready    out_byte[7:0], out_last
//
// One input byte is taken per cycle while the group queue has room; each
// byte yields zero to three decoded bytes, sent from the output register
// one per cycle while out_ch.ready is high; a broken escape adds up to two.
// Reset (rst_n low, synchronous) clears the escape state and the queue.
// A stalled output fills the QueueDepth-entry queue, then in_ch.ready drops.

module url_percent_decoder #(
  parameter int QueueDepth = upd_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  upd_in_if.sink    in_ch,
  upd_out_if.source out_ch
);
  import upd_pkg::*;

  grp_t wr_grp;
  grp_t rd_grp;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  upd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .grp    (wr_grp)
  );

  upd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wr    (wr_grp),
    .full  (q_full),
    .pop   (pop),
    .rd    (rd_grp),
    .empty (q_empty)
  );

  upd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .out_ch (out_ch),
    .rd     (rd_grp),
    .empty  (q_empty),
    .pop    (pop)
  );

endmodule

>>> hdl/upd_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module upd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  logic [8:0] out_beat;

  assign out_beat = {out_byte, out_last};

  // a stalled output beat holds
  `UPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat))

  // reset empties the block: nothing to send, room to take input
  `UPD_ASSERT_NEXT_NR(a_rst_clear, !rst_n, !out_valid && in_ready)

  // input backpressure only arises behind pending output
  `UPD_ASSERT_NOW(a_bp_pending, !in_ready, out_valid)

  // an input beat never waits while the block shows nothing
  `UPD_ASSERT_NOW(a_no_idle_stall, in_valid && !out_valid, in_ready)

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.out_last)
);
